// ----- rtl/bdel_pkg.sv -----
// Shared types and codes for the bounded double-ended list.
`timescale 1ns / 1ps

package bdel_pkg;

  localparam int unsigned BDEL_CAPACITY = 64;
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned POS_W         = 6;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

  // result status
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] read_value;
    logic [POS_W-1:0]         position;
    logic                     last;
  } rsp_t;

endpackage

// ----- rtl/bounded_double_ended_list.sv -----
// Bounded double-ended list: a ring of words in one synchronous memory.
`timescale 1ns / 1ps

// A request is taken when start_i is high and busy_o is low; every result is
// shown on rsp_o for exactly one cycle with done_o high, and the receiver has
// no way to hold it off. Results appear the cycle after they are produced.
// Pushes and all error cases leave the block idle, so a new request can follow
// in the next cycle. A pop passes through ST_POP: the memory's registered read
// keeps busy_o high while the word comes back. A dump of N words passes through
// ST_DUMP, streaming one word per cycle as the read pointer walks the ring from
// the front; busy_o stays high until the last word is out. Unknown request
// kinds are dropped with no result. No clearing pass is needed after reset.
module bounded_double_ended_list #(
  parameter int unsigned CAPACITY = bdel_pkg::BDEL_CAPACITY
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  bdel_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output bdel_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_DUMP = 2'd2;

  // ring address a + b, both operands below CAPACITY
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [AW:0] sum;
    sum = (AW+1)'(a) + (AW+1)'(b);
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] daddr_q, daddr_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          done_q, done_d;
  bdel_pkg::rsp_t rsp_q, rsp_d;

  logic signed [bdel_pkg::WORD_W-1:0] mem_q [CAPACITY];
  logic signed [bdel_pkg::WORD_W-1:0] rdata_q;
  logic [AW-1:0] raddr, waddr;
  logic          mem_we;

  logic accept, full, empty;

  assign accept = start_i && (state_q == ST_IDLE);
  assign full   = (count_q == CW'(CAPACITY));
  assign empty  = (count_q == '0);

  always_comb begin
    state_d = state_q;
    front_d = front_q;
    count_d = count_q;
    daddr_d = daddr_q;
    idx_d   = idx_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    raddr   = daddr_q;
    waddr   = wrap_add(front_q, count_q);
    mem_we  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rsp_d.status     = bdel_pkg::STATUS_OK;
          rsp_d.read_value = '0;
          rsp_d.position   = '0;
          rsp_d.last       = 1'b1;
          case (req_i.kind) inside
            bdel_pkg::KIND_PUSH_FRONT, bdel_pkg::KIND_PUSH_BACK: begin
              done_d = 1'b1;
              if (full) begin
                rsp_d.status = bdel_pkg::STATUS_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
                if (req_i.kind == bdel_pkg::KIND_PUSH_FRONT) begin
                  waddr   = (front_q == '0) ? AW'(CAPACITY - 1) : front_q - AW'(1);
                  front_d = waddr;
                end
              end
            end
            bdel_pkg::KIND_POP_FRONT, bdel_pkg::KIND_POP_BACK: begin
              if (empty) begin
                done_d       = 1'b1;
                rsp_d.status = bdel_pkg::STATUS_EMPTY;
              end else begin
                state_d = ST_POP;
                count_d = count_q - CW'(1);
                if (req_i.kind == bdel_pkg::KIND_POP_FRONT) begin
                  raddr   = front_q;
                  front_d = wrap_add(front_q, CW'(1));
                end else begin
                  raddr = wrap_add(front_q, count_q - CW'(1));
                end
              end
            end
            bdel_pkg::KIND_DUMP: begin
              if (empty) begin
                done_d       = 1'b1;
                rsp_d.status = bdel_pkg::STATUS_EMPTY;
              end else begin
                state_d = ST_DUMP;
                raddr   = front_q;
                daddr_d = wrap_add(front_q, CW'(1));
                idx_d   = '0;
              end
            end
            default: ;  // unused kinds: no result
          endcase
        end
      end
      ST_POP: begin
        done_d           = 1'b1;
        rsp_d.status     = bdel_pkg::STATUS_OK;
        rsp_d.read_value = rdata_q;
        rsp_d.position   = '0;
        rsp_d.last       = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_DUMP: begin
        // rdata_q holds the word at idx_q; fetch the next one meanwhile
        done_d           = 1'b1;
        rsp_d.status     = bdel_pkg::STATUS_OK;
        rsp_d.read_value = rdata_q;
        rsp_d.position   = bdel_pkg::POS_W'(idx_q);
        rsp_d.last       = (CW'(idx_q) == count_q - CW'(1));
        raddr            = daddr_q;
        daddr_d          = wrap_add(daddr_q, CW'(1));
        idx_d            = idx_q + AW'(1);
        if (rsp_d.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      front_q <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    daddr_q <= daddr_d;
    idx_q   <= idx_d;
    rsp_q   <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= req_i.item_value;
    end
    rdata_q <= mem_q[raddr];
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CW'(CAPACITY)) && ((AW+1)'(front_q) < (AW+1)'(CAPACITY)))
    else $error("ring pointer or count out of range");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |=> (done_o && rsp_o.last))
    else $error("pop read did not produce a result");

  a_dump_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |=> done_o)
    else $error("dump skipped a beat");

  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.last) |-> (state_q == ST_DUMP))
    else $error("non-final beat outside a dump");

  a_dump_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> $stable(count_q))
    else $error("list changed during dump");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the bounded double-ended list, with a deque predictor.
`timescale 1ns / 1ps

module tb;
  import bdel_pkg::*;

  localparam int unsigned CAP        = BDEL_CAPACITY;
  localparam int unsigned STALL_LIMIT = 2000;

  logic  clk_i;
  logic  rst_ni;
  logic  start_i;
  req_t  req_i;
  logic  busy_o;
  logic  done_o;
  rsp_t  rsp_o;

  bounded_double_ended_list DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // predicted list contents, kept as a ring like the block's
  logic signed [WORD_W-1:0] ring_words [CAP];
  int unsigned head_idx;
  int unsigned held_count;
  rsp_t        expected_rsps [$];

  int unsigned error_count;
  int unsigned stall_cycles;
  bit          pace_gaps;
  bit          growing;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void apply_request(req_t req);
    rsp_t r;
    r      = '0;
    r.last = 1'b1;
    case (req.kind) inside
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (held_count >= CAP) begin
          r.status = STATUS_FULL;
        end else begin
          if (req.kind == KIND_PUSH_FRONT) begin
            head_idx             = (head_idx + CAP - 1) % CAP;
            ring_words[head_idx] = req.item_value;
          end else begin
            ring_words[(head_idx + held_count) % CAP] = req.item_value;
          end
          held_count++;
          r.status = STATUS_OK;
        end
        expected_rsps.push_back(r);
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (held_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.status = STATUS_OK;
          if (req.kind == KIND_POP_FRONT) begin
            r.read_value = ring_words[head_idx];
            head_idx     = (head_idx + 1) % CAP;
          end else begin
            r.read_value = ring_words[(head_idx + held_count - 1) % CAP];
          end
          held_count--;
        end
        expected_rsps.push_back(r);
      end
      KIND_DUMP: begin
        if (held_count == 0) begin
          r.status = STATUS_EMPTY;
          expected_rsps.push_back(r);
        end else begin
          for (int unsigned i = 0; i < held_count; i++) begin
            r.status     = STATUS_OK;
            r.read_value = ring_words[(head_idx + i) % CAP];
            r.position   = i[POS_W-1:0];
            r.last       = (i + 1 == held_count);
            expected_rsps.push_back(r);
          end
        end
      end
      default: ; // unused kinds are dropped without a result
    endcase
  endfunction

  // inputs move on falling edges, so both beats are safe to sample here
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o || (start_i && !busy_o)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (done_o) begin
        rsp_t exp_rsp;
        if (expected_rsps.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result beat, expected none, actual %p", $time, rsp_o);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp_o.status !== exp_rsp.status) begin
            error_count++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, exp_rsp.status, rsp_o.status);
          end
          if (rsp_o.read_value !== exp_rsp.read_value) begin
            error_count++;
            $display("%0t: read_value mismatch, expected %0d, actual %0d",
                     $time, exp_rsp.read_value, rsp_o.read_value);
          end
          if (rsp_o.position !== exp_rsp.position) begin
            error_count++;
            $display("%0t: position mismatch, expected %0d, actual %0d",
                     $time, exp_rsp.position, rsp_o.position);
          end
          if (rsp_o.last !== exp_rsp.last) begin
            error_count++;
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, exp_rsp.last, rsp_o.last);
          end
        end
      end
      if (start_i && !busy_o) begin
        apply_request(req_i);
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_req(input logic [KIND_W-1:0] kind, input logic signed [WORD_W-1:0] value);
    int unsigned gap;
    gap = pace_gaps ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i         <= 1'b1;
    req_i.kind       <= kind;
    req_i.item_value <= value;
    do @(posedge clk_i); while (busy_o);
  endtask

  // hold off new requests until every predicted result beat has arrived
  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_list();
    send_req(KIND_POP_FRONT, 32'sd11);
    send_req(KIND_POP_BACK, -32'sd11);
    send_req(KIND_DUMP, '0);
    for (int k = 5; k < 8; k++) send_req(k[KIND_W-1:0], 32'sh5A5A_A5A5);
  endtask

  task automatic test_single_ops();
    send_req(KIND_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_req(KIND_PUSH_BACK, 32'sh8000_0000);
    send_req(KIND_PUSH_FRONT, '0);
    send_req(KIND_PUSH_BACK, -32'sd1);
    send_req(KIND_DUMP, '0);
    send_req(KIND_POP_FRONT, '0);
    send_req(KIND_POP_BACK, '0);
    send_req(KIND_DUMP, '0);
    send_req(KIND_POP_FRONT, '0);
    send_req(KIND_POP_BACK, '0);
    // push and pop on a one-word list, with random gaps between requests
    send_req(KIND_PUSH_BACK, 32'sh1234_5678);
    send_req(KIND_POP_FRONT, '0);
    send_req(KIND_PUSH_FRONT, -32'sh1234_5678);
    send_req(KIND_POP_BACK, '0);
    send_req(KIND_POP_FRONT, '0);
  endtask

  task automatic test_fill_to_capacity();
    int unsigned room;
    wait_drained();
    room = CAP - held_count;
    pace_gaps = 1'b0;
    for (int unsigned i = 0; i < room; i++) begin
      send_req($urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, pick_word());
    end
    pace_gaps = 1'b1;
    send_req(KIND_PUSH_FRONT, 32'sh0BAD_F00D);
    send_req(KIND_PUSH_BACK, 32'sh0BAD_F00D);
    send_req(KIND_DUMP, '0);
    wait_drained();
    for (int unsigned i = 0; i < CAP; i++) begin
      send_req($urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT, '0);
      if (i % 16 == 15) pace_gaps = ~pace_gaps;
    end
    send_req(KIND_DUMP, '0);
    pace_gaps = 1'b1;
  endtask

  task automatic test_random_mix(input int unsigned n_items);
    int unsigned roll;
    logic [KIND_W-1:0] kind;
    for (int unsigned n = 0; n < n_items; n++) begin
      if (n % 50 == 0) pace_gaps = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 29) == 0) growing = ~growing;
      if (growing && held_count >= CAP && $urandom_range(0, 3) == 0) growing = 1'b0;
      if (!growing && held_count == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        kind = KIND_W'($urandom_range(5, 7));
      end else if (roll < 9) begin
        kind = KIND_DUMP;
      end else if ((roll < 70) == growing) begin
        kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
      end else begin
        kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
      end
      send_req(kind, pick_word());
      if (n == n_items / 2) wait_drained();
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_i        = '0;
    head_idx     = 0;
    held_count   = 0;
    error_count  = 0;
    stall_cycles = 0;
    pace_gaps    = 1'b1;
    growing      = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_single_ops();
    test_fill_to_capacity();
    test_random_mix(330);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- bounded_double_ended_list.f -----
rtl/bdel_pkg.sv
rtl/bounded_double_ended_list.sv
verif/tb.sv
